// ----- src/as2f_pkg.sv -----
// ----------------------------------------------------------------------------
// as2f_pkg
// Shared types and constants for the audio sample to float32 converter.
// ----------------------------------------------------------------------------
package as2f_pkg;

  localparam logic [1:0] FMT_I32 = 2'd0;
  localparam logic [1:0] FMT_F16 = 2'd1;
  localparam logic [1:0] FMT_F64 = 2'd2;
  localparam logic [1:0] FMT_F32 = 2'd3;

  // rounder word width, leading-one search group width, position width
  localparam int RW = 80;
  localparam int GW = 16;
  localparam int NG = RW / GW;
  localparam int PW = 7;
  // fixed-point width of a small single in units of 2^-149
  localparam int XW = 76;
  // side-band stages ahead of the output register
  localparam int NS = 15;

  // quench constant 1e-30f in units of 2^-149
  localparam logic [XW-1:0] QFIX = {52'd0, 24'hA24260} << 26;
  // singles with a biased exponent at or above this pass the quench unchanged
  localparam logic [7:0] QUENCH_EXP = 8'd53;

  localparam logic [62:0] DBL_INF = 63'h7FF0000000000000;
  localparam logic [62:0] DBL_OVF = 63'h47EFFFFFF0000000;

  typedef struct packed {
    logic [63:0] raw_sample;
    logic        last_sample;
  } in_t;

  typedef struct packed {
    logic [31:0] float_bits;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic          sgn;
    logic [RW-1:0] mag;
  } rnd_in_t;

  typedef struct packed {
    logic          sgn;
    logic [30:0]   enc;
    logic [RW-1:0] value;
  } rnd_out_t;

endpackage

// ----- src/as2f_rnd.sv -----
// ----------------------------------------------------------------------------
// as2f_rnd
// Five-stage rounder: rounds a sign-magnitude integer in units of 2^-149 to
// 24 significant bits, nearest-even, giving the single encoding and value.
// ----------------------------------------------------------------------------
module as2f_rnd (
  input  logic               clk,
  input  logic               en,
  input  as2f_pkg::rnd_in_t  rin,
  output as2f_pkg::rnd_out_t rout
);

  logic                         s1_sgn_r;
  logic [as2f_pkg::RW-1:0]      s1_mag_r;
  logic [as2f_pkg::NG-1:0]      s1_nz_r;
  logic [3:0]                   s1_pos_r [as2f_pkg::NG];
  logic [3:0]                   pos_nxt [as2f_pkg::NG];

  logic                         s2_sgn_r;
  logic [as2f_pkg::RW-1:0]      s2_mag_r;
  logic [as2f_pkg::PW-1:0]      s2_p_r;
  logic [as2f_pkg::PW-1:0]      p_nxt;

  logic                         s3_sgn_r, s3_big_r, s3_g_r, s3_s_r;
  logic [23:0]                  s3_keep_r;
  logic [as2f_pkg::PW-1:0]      s3_p_r;
  logic                         big_nxt, g_nxt, s_nxt;
  logic [23:0]                  keep_nxt;
  logic [as2f_pkg::PW-1:0]      sh;
  logic [as2f_pkg::RW-1:0]      shifted;

  logic                         s4_sgn_r, s4_big_r;
  logic [23:0]                  s4_m_r;
  logic [as2f_pkg::PW-1:0]      s4_p_r;
  logic [24:0]                  sum;

  as2f_pkg::rnd_out_t           out_r;
  as2f_pkg::rnd_out_t           out_nxt;

  always_comb begin
    for (int g = 0; g < as2f_pkg::NG; g++) begin
      pos_nxt[g] = 4'd0;
      for (int b = 0; b < as2f_pkg::GW; b++) begin
        if (rin.mag[g*as2f_pkg::GW+b]) pos_nxt[g] = 4'(b);
      end
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int g = 0; g < as2f_pkg::NG; g++) begin
      if (s1_nz_r[g]) p_nxt = as2f_pkg::PW'(g*as2f_pkg::GW) + as2f_pkg::PW'(s1_pos_r[g]);
    end
  end

  always_comb begin
    big_nxt = (s2_p_r >= as2f_pkg::PW'(24));
    sh      = s2_p_r - as2f_pkg::PW'(23);
    shifted = s2_mag_r >> (sh - as2f_pkg::PW'(1));
    if (big_nxt) begin
      keep_nxt = shifted[24:1];
      g_nxt    = shifted[0];
      s_nxt    = |(s2_mag_r & ~({as2f_pkg::RW{1'b1}} << (sh - as2f_pkg::PW'(1))));
    end else begin
      keep_nxt = s2_mag_r[23:0];
      g_nxt    = 1'b0;
      s_nxt    = 1'b0;
    end
  end

  assign sum = {1'b0, s3_keep_r} + 25'(s3_g_r & (s3_s_r | s3_keep_r[0]));

  always_comb begin
    out_nxt.sgn = s4_sgn_r;
    if (s4_big_r) begin
      out_nxt.enc   = {8'(s4_p_r - as2f_pkg::PW'(22)), s4_m_r[22:0]};
      out_nxt.value = {{(as2f_pkg::RW-24){1'b0}}, s4_m_r} << (s4_p_r - as2f_pkg::PW'(23));
    end else begin
      out_nxt.enc   = {7'd0, s4_m_r};
      out_nxt.value = {{(as2f_pkg::RW-24){1'b0}}, s4_m_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sgn_r <= rin.sgn;
      s1_mag_r <= rin.mag;
      for (int g = 0; g < as2f_pkg::NG; g++) begin
        s1_nz_r[g]  <= |rin.mag[g*as2f_pkg::GW +: as2f_pkg::GW];
        s1_pos_r[g] <= pos_nxt[g];
      end
      s2_sgn_r  <= s1_sgn_r;
      s2_mag_r  <= s1_mag_r;
      s2_p_r    <= p_nxt;
      s3_sgn_r  <= s2_sgn_r;
      s3_big_r  <= big_nxt;
      s3_g_r    <= g_nxt;
      s3_s_r    <= s_nxt;
      s3_keep_r <= keep_nxt;
      s3_p_r    <= s2_p_r;
      s4_sgn_r  <= s3_sgn_r;
      s4_big_r  <= s3_big_r;
      if (sum[24]) begin
        s4_m_r <= sum[24:1];
        s4_p_r <= s3_p_r + as2f_pkg::PW'(1);
      end else begin
        s4_m_r <= sum[23:0];
        s4_p_r <= s3_p_r;
      end
      out_r <= out_nxt;
    end
  end

  assign rout = out_r;

endmodule

// ----- src/audio_sample_to_float32.sv -----
// ----------------------------------------------------------------------------
// audio_sample_to_float32
// Converts int32, float16, float64 or float32 sample bits to single floats.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and out_ready is low.
// Reset: clears all stage valid bits and sets the source format to int32.
// ----------------------------------------------------------------------------
module audio_sample_to_float32 (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  as2f_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output as2f_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_data
);

  typedef struct packed {
    logic        last;
    logic        done;
    logic        sgn;
    logic [31:0] res;
  } side_t;

  logic [1:0]             fmt_r;
  logic                   en;
  logic [as2f_pkg::NS:0]  vld_r;
  side_t                  side_r [as2f_pkg::NS];
  side_t                  side_nxt [as2f_pkg::NS];
  side_t                  dec_nxt;

  logic [63:0]            raw;
  logic [10:0]            dexp, k;
  logic [52:0]            sig;
  logic [116:0]           wide;
  logic [4:0]             hexp;
  logic [9:0]             hman;
  logic [3:0]             hpos;
  logic [9:0]             hnorm;

  logic [30:0]            word_nxt;
  logic                   g_nxt, s_nxt;
  logic [31:0]            imag_nxt;
  logic [30:0]            s0_word_r;
  logic                   s0_g_r, s0_s_r;
  logic [31:0]            s0_imag_r;

  logic [30:0]            s1_x_r;
  logic [31:0]            s1_imag_r;

  logic [as2f_pkg::XW-1:0] xw_nxt;
  logic [as2f_pkg::XW-1:0] s2_xw_r;

  as2f_pkg::rnd_in_t      ra_nxt, ra_in_r;
  as2f_pkg::rnd_out_t     ra_out;
  as2f_pkg::rnd_in_t      rb_nxt, rb_in_r;
  as2f_pkg::rnd_out_t     rb_out;
  logic [as2f_pkg::RW-1:0] qw;
  logic [30:0]            ienc;
  as2f_pkg::out_t         out_r, out_nxt;

  assign en        = ~vld_r[as2f_pkg::NS] | out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign raw       = in_data.raw_sample;
  assign qw        = as2f_pkg::RW'(as2f_pkg::QFIX);

  // input decode
  always_comb begin
    dec_nxt.last = in_data.last_sample;
    dec_nxt.done = 1'b1;
    dec_nxt.sgn  = 1'b0;
    dec_nxt.res  = raw[31:0];
    word_nxt = '0;
    g_nxt    = 1'b0;
    s_nxt    = 1'b0;
    imag_nxt = raw[31] ? (~raw[31:0] + 32'd1) : raw[31:0];
    dexp     = raw[62:52];
    sig      = {dexp != 11'd0, raw[51:0]};
    k        = (dexp == 11'd0) ? 11'd925 : (11'd926 - dexp);
    wide     = {sig, 64'd0} >> k[5:0];
    hexp     = raw[14:10];
    hman     = raw[9:0];
    hpos     = 4'd0;
    for (int b = 0; b < 10; b++) begin
      if (hman[b]) hpos = 4'(b);
    end
    hnorm    = hman << (4'd10 - hpos);
    case (fmt_r)
      as2f_pkg::FMT_I32: begin
        dec_nxt.done = 1'b0;
        dec_nxt.sgn  = raw[31];
      end
      as2f_pkg::FMT_F16: begin
        if (hexp == 5'h1F) begin
          dec_nxt.res = (hman == 10'd0) ? {raw[15], 31'h7F800000} :
                        {raw[15], 8'hFF, 1'b1, hman[8:0], 13'd0};
        end else if (hexp == 5'd0) begin
          dec_nxt.res = (hman == 10'd0) ? {raw[15], 31'd0} :
                        {raw[15], 8'(hpos) + 8'd87, hnorm, 13'd0};
        end else begin
          dec_nxt.res = {raw[15], 8'(hexp) + 8'd96, hman, 13'd0};
        end
      end
      as2f_pkg::FMT_F64: begin
        dec_nxt.sgn = raw[63];
        if (raw[62:0] > as2f_pkg::DBL_INF) begin
          dec_nxt.res = {raw[63], 8'hFF, 1'b1, raw[50:29]};
        end else if (raw[62:0] >= as2f_pkg::DBL_OVF) begin
          dec_nxt.res = {raw[63], 31'h7F800000};
        end else begin
          dec_nxt.done = 1'b0;
          if (dexp >= 11'd897) begin
            word_nxt = {8'(dexp - 11'd896), raw[51:29]};
            g_nxt    = raw[28];
            s_nxt    = |raw[27:0];
          end else if (k < 11'd64) begin
            word_nxt = wide[94:64];
            g_nxt    = wide[63];
            s_nxt    = |wide[62:0];
          end
        end
      end
      default: begin
        dec_nxt.res = raw[31:0];
      end
    endcase
  end

  // quench screen, fixed-point expansion and int32 result encoding
  always_comb begin
    side_nxt[0] = dec_nxt;
    for (int i = 1; i < as2f_pkg::NS; i++) side_nxt[i] = side_r[i-1];
    xw_nxt = {{(as2f_pkg::XW-32){1'b0}}, s1_imag_r} << 24;
    if (fmt_r == as2f_pkg::FMT_F64 && !side_r[1].done) begin
      if (s1_x_r[30:23] >= as2f_pkg::QUENCH_EXP) begin
        side_nxt[2].done = 1'b1;
        side_nxt[2].res  = {side_r[1].sgn, s1_x_r};
      end
      if (s1_x_r[30:23] == 8'd0) begin
        xw_nxt = {{(as2f_pkg::XW-23){1'b0}}, s1_x_r[22:0]};
      end else begin
        xw_nxt = {{(as2f_pkg::XW-24){1'b0}}, 1'b1, s1_x_r[22:0]} << (s1_x_r[30:23] - 8'd1);
      end
    end
    ienc = ra_out.enc + {8'd94, 23'd0};
    if (fmt_r == as2f_pkg::FMT_I32) begin
      side_nxt[9].done = 1'b1;
      side_nxt[9].res  = (ra_out.enc == 31'd0) ? 32'd0 : {side_r[8].sgn, ienc};
    end
  end

  // add the quench constant to float64 samples
  always_comb begin
    ra_nxt.sgn = side_r[2].sgn;
    ra_nxt.mag = as2f_pkg::RW'(s2_xw_r);
    if (fmt_r == as2f_pkg::FMT_F64) begin
      if (!side_r[2].sgn) begin
        ra_nxt.sgn = 1'b0;
        ra_nxt.mag = as2f_pkg::RW'(s2_xw_r) + qw;
      end else if (s2_xw_r > as2f_pkg::QFIX) begin
        ra_nxt.sgn = 1'b1;
        ra_nxt.mag = as2f_pkg::RW'(s2_xw_r - as2f_pkg::QFIX);
      end else begin
        ra_nxt.sgn = 1'b0;
        ra_nxt.mag = as2f_pkg::RW'(as2f_pkg::QFIX - s2_xw_r);
      end
    end
  end

  // subtract the quench constant
  always_comb begin
    if (ra_out.sgn) begin
      rb_nxt.sgn = 1'b1;
      rb_nxt.mag = ra_out.value + qw;
    end else if (ra_out.value >= qw) begin
      rb_nxt.sgn = 1'b0;
      rb_nxt.mag = ra_out.value - qw;
    end else begin
      rb_nxt.sgn = 1'b1;
      rb_nxt.mag = qw - ra_out.value;
    end
  end

  always_comb begin
    out_nxt.last_out   = side_r[as2f_pkg::NS-1].last;
    out_nxt.float_bits = side_r[as2f_pkg::NS-1].done ? side_r[as2f_pkg::NS-1].res :
                         {rb_out.sgn, rb_out.enc};
  end

  as2f_rnd u_rnd_a (
    .clk  (clk),
    .en   (en),
    .rin  (ra_in_r),
    .rout (ra_out)
  );

  as2f_rnd u_rnd_b (
    .clk  (clk),
    .en   (en),
    .rin  (rb_in_r),
    .rout (rb_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fmt_r <= as2f_pkg::FMT_I32;
    end else begin
      if (cfg_valid && cfg_ready) fmt_r <= cfg_data;
      if (en) vld_r <= {vld_r[as2f_pkg::NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < as2f_pkg::NS; i++) side_r[i] <= side_nxt[i];
      s0_word_r <= word_nxt;
      s0_g_r    <= g_nxt;
      s0_s_r    <= s_nxt;
      s0_imag_r <= imag_nxt;
      s1_x_r    <= s0_word_r + 31'(s0_g_r & (s0_s_r | s0_word_r[0]));
      s1_imag_r <= s0_imag_r;
      s2_xw_r   <= xw_nxt;
      ra_in_r   <= ra_nxt;
      rb_in_r   <= rb_nxt;
      out_r     <= out_nxt;
    end
  end

  assign out_valid = vld_r[as2f_pkg::NS];
  assign out_data  = out_r;

endmodule
